// ===== hdl/matrix4_row_multiply_top_defines.svh =====
// ----------------------------------------------------------------------------
// matrix4_row_multiply_top_defines
// assertion macros used by the matrix row multiplier checker
// ----------------------------------------------------------------------------
`ifndef MATRIX4_ROW_MULTIPLY_TOP_DEFINES_SVH
`define MATRIX4_ROW_MULTIPLY_TOP_DEFINES_SVH

// same-cycle implication, masked while in reset
`define M4RM_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("m4rm check failed");

// next-cycle implication, masked while in reset
`define M4RM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("m4rm check failed");

// condition that must hold in the cycle after reset is seen
`define M4RM_ASSERT_AFTER_RESET(label, cons) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error("m4rm reset check failed");

`endif

// ===== hdl/m4rm_pkg.sv =====
// ----------------------------------------------------------------------------
// m4rm_pkg
// shared constants and types for the 4x4 matrix row multiplier
// ----------------------------------------------------------------------------
package m4rm_pkg;

  localparam int DIM         = 4;
  localparam int ROW_W       = $clog2(DIM);
  localparam int ELEM_W      = 32;
  localparam int PROD_W      = 2 * ELEM_W;
  localparam int SUM_W       = PROD_W + $clog2(DIM);
  localparam int FRAC_W      = 16;
  localparam int IN_TDATA_W  = ((ROW_W + DIM * ELEM_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = DIM * ELEM_W;

  localparam logic [ELEM_W-1:0] SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_MUL  = 1'b1
  } kind_t;

  typedef struct packed {
    logic                         valid;
    kind_t                        kind;
    logic [ROW_W-1:0]             row_index;
    logic [DIM-1:0][ELEM_W-1:0]   elem;
    logic [DIM-1:0][SUM_W-1:0]    psum;
  } token_t;

  typedef struct packed {
    logic                         valid;
    logic [DIM-1:0][ELEM_W-1:0]   data;
    logic                         saturated;
  } result_t;

endpackage

// ===== hdl/m4rm_cell.sv =====
// ----------------------------------------------------------------------------
// m4rm_cell
// one chain cell: holds one right-matrix row, multiplies and accumulates
// ----------------------------------------------------------------------------
module m4rm_cell
  import m4rm_pkg::*;
#(
  parameter int CELL_INDEX = 0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  token_t tok_i,
  output token_t tok_o
);

  logic [DIM-1:0][ELEM_W-1:0] row_r, row_nxt;
  logic [DIM-1:0][PROD_W-1:0] prod_r, prod_nxt;
  token_t                     mul_r;
  token_t                     add_r, add_nxt;

  always_comb begin
    row_nxt = row_r;
    if (tok_i.valid && (tok_i.kind == KIND_LOAD) &&
        (tok_i.row_index == ROW_W'(CELL_INDEX))) begin
      row_nxt = tok_i.elem;
    end
  end

  // products against the stored row, before any later load reaches the cell
  always_comb begin
    for (int c = 0; c < DIM; c++) begin
      prod_nxt[c] = PROD_W'($signed(tok_i.elem[CELL_INDEX]) * $signed(row_r[c]));
    end
  end

  always_comb begin
    add_nxt = mul_r;
    for (int c = 0; c < DIM; c++) begin
      add_nxt.psum[c] = mul_r.psum[c] + SUM_W'($signed(prod_r[c]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      mul_r <= '0;
      add_r <= '0;
    end else if (en) begin
      row_r <= row_nxt;
      mul_r <= tok_i;
      add_r <= add_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  assign tok_o = add_r;

endmodule

// ===== hdl/m4rm_sat.sv =====
// ----------------------------------------------------------------------------
// m4rm_sat
// drops the fraction bits of each sum and clamps it to 32 bits
// ----------------------------------------------------------------------------
module m4rm_sat
  import m4rm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  token_t  tok_i,
  output result_t res_o
);

  result_t res_r, res_nxt;
  logic [SUM_W-FRAC_W-ELEM_W:0] hi;
  logic                         clamp;

  always_comb begin
    res_nxt           = '0;
    res_nxt.valid     = tok_i.valid && (tok_i.kind == KIND_MUL);
    res_nxt.saturated = 1'b0;
    hi                = '0;
    clamp             = 1'b0;
    for (int c = 0; c < DIM; c++) begin
      hi    = tok_i.psum[c][SUM_W-1:FRAC_W+ELEM_W-1];
      clamp = !((&hi) || !(|hi));
      if (!clamp) begin
        res_nxt.data[c] = tok_i.psum[c][FRAC_W+ELEM_W-1:FRAC_W];
      end else if (tok_i.psum[c][SUM_W-1]) begin
        res_nxt.data[c] = SAT_MIN;
      end else begin
        res_nxt.data[c] = SAT_MAX;
      end
      res_nxt.saturated = res_nxt.saturated | clamp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res_o = res_r;

endmodule

// ===== hdl/matrix4_row_multiply_top.sv =====
// ----------------------------------------------------------------------------
// matrix4_row_multiply_top
// 4x4 Q16.16 matrix multiplier fed one row per request
// ----------------------------------------------------------------------------
// in_*  : one row per request. in_tuser selects load (0) or multiply (1).
//         a load writes row in_tdata[1:0] of the stored right-hand matrix and
//         gives no output; a multiply gives one product row on out_*.
// out_* : four saturated Q16.16 columns, in_tuser-style flag on out_tuser
//         set when any column was clamped.
// throughput: one request per cycle while in_tready is high, loads and multiplies mixed freely.
// pipeline: after its request is accepted, a product row passes two stages in each
//           of the four row cells (multiply, then accumulate), one clamp stage and
//           the output register before it shows on out_tvalid.
// the row cells form a chain; a load updates its cell as it passes, so any
// later multiply sees it.
// reset: stored matrix cleared to zero, pipeline and output emptied.
// stall: the output register is backed by a one-entry skid stage; the chain
//        keeps taking requests until the skid stage fills, then in_tready
//        drops until out_tready drains it.
// ----------------------------------------------------------------------------
module matrix4_row_multiply_top
  import m4rm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // row_index, elem0, elem1, elem2, elem3
  input  logic [0:0]             in_tuser,   // kind
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // out0, out1, out2, out3
  output logic [0:0]             out_tuser   // saturated
);

  token_t  chain [DIM+1];
  result_t res;
  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;
  logic    en;
  logic    pop;

  assign en        = !skid_r.valid;
  assign in_tready = en;

  always_comb begin
    chain[0]           = '0;
    chain[0].valid     = in_tvalid;
    chain[0].kind      = kind_t'(in_tuser[0]);
    chain[0].row_index = in_tdata[ROW_W-1:0];
    for (int k = 0; k < DIM; k++) begin
      chain[0].elem[k] = in_tdata[ROW_W + k*ELEM_W +: ELEM_W];
    end
  end

  for (genvar g = 0; g < DIM; g++) begin : g_cell
    m4rm_cell #(
      .CELL_INDEX (g)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .tok_i (chain[g]),
      .tok_o (chain[g+1])
    );
  end

  m4rm_sat u_sat (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .tok_i (chain[DIM]),
    .res_o (res)
  );

  // output register with skid stage behind it
  always_comb begin
    pop      = out_r.valid && out_tready;
    out_nxt  = out_r;
    skid_nxt = skid_r;
    if (!out_r.valid || pop) begin
      if (skid_r.valid) begin
        out_nxt        = skid_r;
        skid_nxt.valid = 1'b0;
      end else begin
        out_nxt       = res;
        out_nxt.valid = en && res.valid;
      end
    end else if (en && res.valid) begin
      skid_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r  <= '0;
      skid_r <= '0;
    end else begin
      out_r  <= out_nxt;
      skid_r <= skid_nxt;
    end
  end

  assign out_tvalid   = out_r.valid;
  assign out_tdata    = out_r.data;
  assign out_tuser[0] = out_r.saturated;

endmodule

// ===== hdl/m4rm_checker.sv =====
// ----------------------------------------------------------------------------
// m4rm_checker
// port-level checks for the matrix row multiplier
// ----------------------------------------------------------------------------
`include "matrix4_row_multiply_top_defines.svh"

module m4rm_checker
  import m4rm_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [0:0]             out_tuser
);

  logic                 out_stall;
  logic [OUT_TDATA_W:0] out_word;
  logic [DIM-1:0]       col_rail;

  assign out_stall = out_tvalid && !out_tready;
  assign out_word  = {out_tuser, out_tdata};

  always_comb begin
    for (int c = 0; c < DIM; c++) begin
      col_rail[c] = (out_tdata[c*ELEM_W +: ELEM_W] == SAT_MAX) ||
                    (out_tdata[c*ELEM_W +: ELEM_W] == SAT_MIN);
    end
  end

  // a stalled result holds its value
  `M4RM_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_word))

  // the input side only backs off while a result is waiting
  `M4RM_ASSERT_IMPLY(a_ready_stall, !in_tready, out_tvalid)

  // a clamped row carries a rail value in at least one column
  `M4RM_ASSERT_IMPLY(a_sat_rail, out_tvalid && out_tuser[0], |col_rail)

  // reset empties the output and opens the input
  `M4RM_ASSERT_AFTER_RESET(a_reset_state, !out_tvalid && in_tready)

endmodule

bind matrix4_row_multiply_top m4rm_checker u_m4rm_checker (.*);

// ===== dv/matrix4_row_multiply_top_test.sv =====
// ----------------------------------------------------------------------------
// matrix4_row_multiply_top_test
// self-checking bench for the 4x4 q16.16 row multiplier: loads fill the
// stored right-hand matrix, multiplies are predicted at full width with
// floor shift and clamp, and product rows are compared in order
// ----------------------------------------------------------------------------
module matrix4_row_multiply_top_test
  import m4rm_pkg::*;
();

  typedef struct {
    kind_t                      kind;
    logic [ROW_W-1:0]           row;
    logic [DIM-1:0][ELEM_W-1:0] elem;
  } row_req_t;

  typedef struct {
    logic [DIM-1:0][ELEM_W-1:0] col;
    logic                       sat;
  } prod_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [0:0]             in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]             out_tuser;

  row_req_t    req_queue[$];
  prod_row_t   expected_rows[$];
  row_req_t    cur_req;
  logic [ELEM_W-1:0] right_rows [DIM][DIM];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_queued = 0;
  int n_accepted = 0;
  int n_loads = 0;
  int n_muls = 0;
  int n_checked = 0;
  int n_sat_seen = 0;
  int n_errors = 0;

  matrix4_row_multiply_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [IN_TDATA_W-1:0] pack_row(input row_req_t r);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[ROW_W-1:0] = r.row;
    for (int k = 0; k < DIM; k++) begin
      d[ROW_W + k*ELEM_W +: ELEM_W] = r.elem[k];
    end
    return d;
  endfunction

  // full-width dot products, floor shift, clamp to 32 bits
  function automatic prod_row_t predict_product(input logic [DIM-1:0][ELEM_W-1:0] a);
    prod_row_t res;
    logic signed [SUM_W-1:0] acc;
    logic signed [SUM_W-1:0] shifted;
    logic signed [SUM_W-1:0] hi_lim;
    logic signed [SUM_W-1:0] lo_lim;
    longint p;
    hi_lim = $signed({{(SUM_W-ELEM_W){1'b0}}, SAT_MAX});
    lo_lim = $signed({{(SUM_W-ELEM_W){1'b1}}, SAT_MIN});
    res.sat = 1'b0;
    for (int c = 0; c < DIM; c++) begin
      acc = '0;
      for (int k = 0; k < DIM; k++) begin
        p = longint'($signed(a[k])) * longint'($signed(right_rows[k][c]));
        acc = acc + p;
      end
      shifted = acc >>> FRAC_W;
      if (shifted > hi_lim) begin
        res.col[c] = SAT_MAX;
        res.sat = 1'b1;
      end else if (shifted < lo_lim) begin
        res.col[c] = SAT_MIN;
        res.sat = 1'b1;
      end else begin
        res.col[c] = shifted[ELEM_W-1:0];
      end
    end
    return res;
  endfunction

  function automatic logic [ELEM_W-1:0] rand_elem();
    logic [ELEM_W-1:0] r;
    r = $urandom;
    case ($urandom_range(9))
      0, 1, 2, 3: rand_elem = r;
      4, 5, 6:    rand_elem = {{12{r[19]}}, r[19:0]};
      7:          rand_elem = {{8{r[23]}}, r[23:0]};
      default: begin
        case ($urandom_range(4))
          0:       rand_elem = SAT_MAX;
          1:       rand_elem = SAT_MIN;
          2:       rand_elem = '1;
          3:       rand_elem = 32'h0001_0000;
          default: rand_elem = '0;
        endcase
      end
    endcase
  endfunction

  task automatic push_req(input kind_t kind, input int row, input logic [ELEM_W-1:0] e0,
                          input logic [ELEM_W-1:0] e1, input logic [ELEM_W-1:0] e2,
                          input logic [ELEM_W-1:0] e3);
    row_req_t r;
    r.kind = kind;
    r.row = ROW_W'(row);
    r.elem[0] = e0;
    r.elem[1] = e1;
    r.elem[2] = e2;
    r.elem[3] = e3;
    req_queue.push_back(r);
    n_queued++;
  endtask

  task automatic push_random(input int count);
    for (int i = 0; i < count; i++) begin
      // now and then a full reload of the matrix, otherwise a mix
      if ($urandom_range(19) == 0) begin
        for (int r = 0; r < DIM; r++) begin
          push_req(KIND_LOAD, r, rand_elem(), rand_elem(), rand_elem(), rand_elem());
        end
        i += DIM - 1;
      end else begin
        push_req(($urandom_range(99) < 35) ? KIND_LOAD : KIND_MUL, $urandom_range(DIM-1),
                 rand_elem(), rand_elem(), rand_elem(), rand_elem());
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        n_accepted++;
        if (cur_req.kind == KIND_LOAD) begin
          for (int c = 0; c < DIM; c++) begin
            right_rows[cur_req.row][c] = cur_req.elem[c];
          end
          n_loads++;
        end else begin
          expected_rows.push_back(predict_product(cur_req.elem));
          n_muls++;
        end
      end
      if (!in_tvalid || in_tready) begin
        if (req_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = req_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= cur_req.kind;
          in_tdata <= pack_row(cur_req);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    prod_row_t exp_row;
    logic      bad;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_rows.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("error: product row with none pending, data %h sat %b",
                     out_tdata, out_tuser);
          end
        end else begin
          exp_row = expected_rows.pop_front();
          n_checked++;
          bad = 1'b0;
          for (int c = 0; c < DIM; c++) begin
            if (out_tdata[c*ELEM_W +: ELEM_W] !== exp_row.col[c]) begin
              bad = 1'b1;
            end
          end
          if (out_tuser[0] !== exp_row.sat) begin
            bad = 1'b1;
          end
          if (exp_row.sat) begin
            n_sat_seen++;
          end
          if (bad) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("error: row %0d expected %h %h %h %h sat %b", n_checked,
                       exp_row.col[0], exp_row.col[1], exp_row.col[2], exp_row.col[3],
                       exp_row.sat);
              $display("       got      %h %h %h %h sat %b",
                       out_tdata[0 +: ELEM_W], out_tdata[ELEM_W +: ELEM_W],
                       out_tdata[2*ELEM_W +: ELEM_W], out_tdata[3*ELEM_W +: ELEM_W],
                       out_tuser[0]);
            end
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    for (int r = 0; r < DIM; r++) begin
      for (int c = 0; c < DIM; c++) begin
        right_rows[r][c] = '0;
      end
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 33;
    recv_idle_pct = 80;
    // multiply before any load gives zeros
    push_req(KIND_MUL, 3, SAT_MAX, SAT_MIN, '1, '0);
    // identity passes the row through
    for (int r = 0; r < DIM; r++) begin
      push_req(KIND_LOAD, r, (r == 0) ? 32'h0001_0000 : '0, (r == 1) ? 32'h0001_0000 : '0,
               (r == 2) ? 32'h0001_0000 : '0, (r == 3) ? 32'h0001_0000 : '0);
    end
    push_req(KIND_MUL, 0, SAT_MAX, SAT_MIN, '1, 32'h0001_0000);
    // most negative everywhere: overflow both ways and cancellation
    for (int r = 0; r < DIM; r++) begin
      push_req(KIND_LOAD, r, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
    end
    push_req(KIND_MUL, 1, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
    push_req(KIND_MUL, 2, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
    push_req(KIND_MUL, 3, SAT_MAX, SAT_MIN, '0, '0);
    push_req(KIND_MUL, 0, '1, '1, '1, '1);
    // most positive everywhere
    for (int r = 0; r < DIM; r++) begin
      push_req(KIND_LOAD, r, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
    end
    push_req(KIND_MUL, 1, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
    push_req(KIND_MUL, 2, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
    push_req(KIND_MUL, 3, '0, '0, '0, '0);
    push_req(KIND_MUL, 0, 32'h0000_0001, '1, 32'h0000_0001, '1);
    push_random(430);
    wait (req_queue.size() == 0);

    send_idle_pct = 80;
    recv_idle_pct = 33;
    push_random(450);
    wait (req_queue.size() == 0);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random(450);

    wait (n_accepted == n_queued && expected_rows.size() == 0);
    repeat (30) @(posedge clk);
    if (expected_rows.size() != 0) begin
      n_errors++;
    end
    $display("covered %0d row loads and %0d multiplies, %0d product rows checked",
             n_loads, n_muls, n_checked);
    $display("%0d of those rows clamped, %0d mismatches", n_sat_seen, n_errors);
    if (n_errors == 0) begin
      $display("PASS matrix4_row_multiply_top");
    end else begin
      $display("FAIL matrix4_row_multiply_top");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL matrix4_row_multiply_top");
    $finish;
  end

endmodule
